// ===== sv/nlss_pkg.sv =====
// Shared constants, register indexes and microcode types for the lambda-set step core.
package nlss_pkg;

   // Fixed field widths of the request, response and configuration channels
   localparam int CMD_W        = 1;
   localparam int ROW_STATE_W  = 5;
   localparam int ROW_COLUMN_W = 4;
   localparam int MASK_W       = 32;
   localparam int SYMBOL_W     = 8;
   localparam int CODES_W      = 64;
   localparam int IN_USE_W     = 4;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE_ROW = 1'b0;
   localparam logic [CMD_W-1:0] CMD_QUERY     = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_CODES   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_IN_USE = 1'b1;

   // Microcode step addresses
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_CLEAR      = 4'd0;
   localparam step_type STEP_IDLE       = 4'd1;
   localparam step_type STEP_LOAD       = 4'd2;
   localparam step_type STEP_CLOSE_FIRST = 4'd3;
   localparam step_type STEP_MOVE_INIT  = 4'd4;
   localparam step_type STEP_MOVE       = 4'd5;
   localparam step_type STEP_LOAD_MOVED = 4'd6;
   localparam step_type STEP_CLOSE_LAST = 4'd7;
   localparam step_type STEP_OUTPUT     = 4'd8;

   // Datapath operation of one control word
   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_IDLE,
      OP_LOAD_START,
      OP_SCAN_CLOSE,
      OP_MOVE_INIT,
      OP_SCAN_MOVE,
      OP_LOAD_MOVED,
      OP_OUTPUT
   } op_type;

   // Jump condition of one control word
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_CLEAR_BUSY,
      COND_IDLE_STAY,
      COND_UNKNOWN,
      COND_SCAN_BUSY,
      COND_OUT_STALL
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump_to;
      step_type fall_to;
   } ucode_type;

   // Control store: next step is jump_to when cond holds, else fall_to
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      unique case (step)
         STEP_CLEAR:       word = '{OP_CLEAR,      COND_CLEAR_BUSY, STEP_CLEAR,       STEP_IDLE};
         STEP_IDLE:        word = '{OP_IDLE,       COND_IDLE_STAY,  STEP_IDLE,        STEP_LOAD};
         STEP_LOAD:        word = '{OP_LOAD_START, COND_UNKNOWN,    STEP_OUTPUT,
                                    STEP_CLOSE_FIRST};
         STEP_CLOSE_FIRST: word = '{OP_SCAN_CLOSE, COND_SCAN_BUSY,  STEP_CLOSE_FIRST,
                                    STEP_MOVE_INIT};
         STEP_MOVE_INIT:   word = '{OP_MOVE_INIT,  COND_NEVER,      STEP_MOVE,        STEP_MOVE};
         STEP_MOVE:        word = '{OP_SCAN_MOVE,  COND_SCAN_BUSY,  STEP_MOVE,
                                    STEP_LOAD_MOVED};
         STEP_LOAD_MOVED:  word = '{OP_LOAD_MOVED, COND_NEVER,      STEP_CLOSE_LAST,
                                    STEP_CLOSE_LAST};
         STEP_CLOSE_LAST:  word = '{OP_SCAN_CLOSE, COND_SCAN_BUSY,  STEP_CLOSE_LAST,
                                    STEP_OUTPUT};
         STEP_OUTPUT:      word = '{OP_OUTPUT,     COND_OUT_STALL,  STEP_OUTPUT,      STEP_IDLE};
         default:          word = '{OP_IDLE,       COND_IDLE_STAY,  STEP_IDLE,        STEP_LOAD};
      endcase
      return word;
   endfunction

endpackage

// ===== sv/nfa_lambda_set_step_core.sv =====
// Lambda-closure subset step of a nondeterministic automaton, run by a microcoded sequencer.
//
// The block keeps the automaton's transition table as one successor mask per state and
// column in a memory with one write port and one registered read port (symbol columns
// first, the lambda column last). A request with cmd = write stores one row and gives no
// response. A query takes the lambda closure of start_set, moves on the column whose
// configured code matches symbol, closes again, and returns one response with result_set,
// is_empty and unknown_symbol. A small control store steps the datapath; every closure
// and move sweep reads one table row per cycle through the memory's one read port, each
// state being expanded once. In a closure, a state reached only through the row just
// read waits for its own read. An unknown symbol skips the sweeps and goes from the load
// step straight to the output step. Each request is taken in the idle step, so writes
// can follow each other every cycle. A finished response sits in its own register, so
// the next request is taken while it waits; the output step holds while an earlier
// response is still waiting. After reset the table is cleared, all
// STATE_COUNT*(SYMBOL_COLUMNS+1) rows (288 at the defaults, states capped at 32), before
// the first request is taken; configuration writes are taken at any time.
module nfa_lambda_set_step_core #(
   parameter int STATE_COUNT    = 32,
   parameter int SYMBOL_COLUMNS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [nlss_pkg::CMD_W-1:0]          req_cmd,
   input  logic [nlss_pkg::ROW_STATE_W-1:0]    req_row_state,
   input  logic [nlss_pkg::ROW_COLUMN_W-1:0]   req_row_column,
   input  logic [nlss_pkg::MASK_W-1:0]         req_row_targets,
   input  logic [nlss_pkg::MASK_W-1:0]         req_start_set,
   input  logic [nlss_pkg::SYMBOL_W-1:0]       req_symbol,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nlss_pkg::MASK_W-1:0]         rsp_result_set,
   output logic                                rsp_is_empty,
   output logic                                rsp_unknown_symbol,
   // configuration port
   input  logic                                csr_we,
   input  logic [nlss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nlss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import nlss_pkg::*;

   // States beyond the mask ports can never be set, so storage stops there
   localparam int STATE_SLOTS  = (STATE_COUNT < MASK_W) ? STATE_COUNT : MASK_W;
   localparam int SET_W        = STATE_SLOTS;
   localparam int SIDX_W       = (STATE_SLOTS > 1) ? $clog2(STATE_SLOTS) : 1;
   localparam int COLUMN_TOTAL = SYMBOL_COLUMNS + 1;
   localparam int COL_W        = $clog2(COLUMN_TOTAL);
   localparam int DEPTH        = STATE_SLOTS * COLUMN_TOTAL;
   localparam int ADDR_W       = $clog2(DEPTH);

   localparam logic [COL_W-1:0]  LAMBDA_COL = COL_W'(SYMBOL_COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

   // Lowest set bit of a state mask
   function automatic logic [SIDX_W-1:0] lowest_index(input logic [SET_W-1:0] mask);
      logic [SIDX_W-1:0] idx;
      idx = '0;
      for (int i = SET_W - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = SIDX_W'(i);
         end
      end
      return idx;
   endfunction

   // Table memory
   logic [SET_W-1:0]  table_mem [DEPTH];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [SET_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [SET_W-1:0]  rd_data_ff;

   // Sequencer and datapath registers
   step_type          step_ff, step_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic [SET_W-1:0]  pend_ff, pend_in;
   logic [SET_W-1:0]  acc_ff, acc_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              found_ff, found_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] rsp_set_ff, rsp_set_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_unknown_ff, rsp_unknown_in;
   logic [CODES_W-1:0]  codes_ff, codes_in;
   logic [IN_USE_W-1:0] in_use_ff, in_use_in;

   ucode_type          uc;
   logic               req_take;
   logic               sym_hit;
   logic [COL_W-1:0]   sym_col;
   logic [IN_USE_W-1:0] cols_used;
   logic               row_ok;
   logic [SET_W-1:0]   pick_onehot;
   logic [SIDX_W-1:0]  pick_idx;
   logic [COL_W-1:0]   scan_col;
   logic               scan_op;
   logic               rd_issue;
   logic               can_load;
   logic               cond_true;

   assign uc        = ucode_rom(step_ff);
   assign req_ready = (uc.op == OP_IDLE);
   assign req_take  = req_valid && req_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_set     = rsp_set_ff;
   assign rsp_is_empty       = rsp_empty_ff;
   assign rsp_unknown_symbol = rsp_unknown_ff;

   // Match the query symbol against the valid columns, lowest column first
   always_comb begin
      cols_used = (int'(in_use_ff) > SYMBOL_COLUMNS) ? IN_USE_W'(SYMBOL_COLUMNS) : in_use_ff;
      sym_hit   = 1'b0;
      sym_col   = '0;
      for (int c = 0; c < SYMBOL_COLUMNS; c++) begin
         if (!sym_hit && (c < int'(cols_used)) && (codes_ff[8*c +: 8] == req_symbol)) begin
            sym_hit = 1'b1;
            sym_col = COL_W'(c);
         end
      end
   end

   assign row_ok = (int'(req_row_state) < STATE_COUNT) &&
                   (int'(req_row_column) <= SYMBOL_COLUMNS);

   // Pick the next pending state and address its row
   assign pick_onehot = pend_ff & (~pend_ff + SET_W'(1));
   assign pick_idx    = lowest_index(pend_ff);
   assign scan_op     = (uc.op == OP_SCAN_CLOSE) || (uc.op == OP_SCAN_MOVE);
   assign scan_col    = (uc.op == OP_SCAN_MOVE) ? col_ff : LAMBDA_COL;
   assign rd_issue    = scan_op && (pend_ff != '0);
   assign mem_raddr   = ADDR_W'(ADDR_W'(pick_idx) * ADDR_W'(COLUMN_TOTAL)) + ADDR_W'(scan_col);
   assign can_load    = !rsp_valid_ff || rsp_ready;

   // Configuration writes
   always_comb begin
      codes_in  = codes_ff;
      in_use_in = in_use_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SYMBOL_CODES:   codes_in  = csr_wdata[CODES_W-1:0];
            CSR_SYMBOLS_IN_USE: in_use_in = csr_wdata[IN_USE_W-1:0];
            default:            codes_in  = codes_ff;
         endcase
      end
   end

   // Datapath of the current control word
   always_comb begin
      clr_addr_in    = clr_addr_ff;
      set_in         = set_ff;
      pend_in        = pend_ff;
      acc_in         = acc_ff;
      found_in       = found_ff;
      col_in         = col_ff;
      rd_valid_in    = rd_issue;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_set_in     = rsp_set_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_unknown_in = rsp_unknown_ff;
      mem_we         = 1'b0;
      mem_waddr      = ADDR_W'(ADDR_W'(req_row_state[SIDX_W-1:0]) * ADDR_W'(COLUMN_TOTAL))
                       + ADDR_W'(req_row_column[COL_W-1:0]);
      mem_wdata      = req_row_targets[SET_W-1:0];

      unique case (uc.op)
         OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff != LAST_ADDR) begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end
         OP_IDLE: begin
            if (req_take) begin
               if (req_cmd == CMD_QUERY) begin
                  set_in   = req_start_set[SET_W-1:0];
                  found_in = sym_hit;
                  col_in   = sym_col;
               end else begin
                  mem_we = row_ok;
               end
            end
         end
         OP_LOAD_START: begin
            // unknown symbol yields the empty set
            set_in  = found_ff ? set_ff : '0;
            pend_in = found_ff ? set_ff : '0;
         end
         OP_SCAN_CLOSE: begin
            pend_in = pend_ff & ~pick_onehot;
            if (rd_valid_ff) begin
               set_in  = set_ff | rd_data_ff;
               pend_in = (pend_ff & ~pick_onehot) | (rd_data_ff & ~set_ff);
            end
         end
         OP_MOVE_INIT: begin
            pend_in = set_ff;
            acc_in  = '0;
         end
         OP_SCAN_MOVE: begin
            pend_in = pend_ff & ~pick_onehot;
            if (rd_valid_ff) begin
               acc_in = acc_ff | rd_data_ff;
            end
         end
         OP_LOAD_MOVED: begin
            set_in  = acc_ff;
            pend_in = acc_ff;
         end
         OP_OUTPUT: begin
            if (can_load) begin
               rsp_valid_in   = 1'b1;
               rsp_set_in     = MASK_W'(set_ff);
               rsp_empty_in   = (set_ff == '0);
               rsp_unknown_in = !found_ff;
            end
         end
         default: begin
            set_in = set_ff;
         end
      endcase
   end

   // Evaluate the jump condition and advance the step counter
   always_comb begin
      unique case (uc.cond)
         COND_NEVER:      cond_true = 1'b0;
         COND_CLEAR_BUSY: cond_true = (clr_addr_ff != LAST_ADDR);
         COND_IDLE_STAY:  cond_true = !(req_take && (req_cmd == CMD_QUERY));
         COND_UNKNOWN:    cond_true = !found_ff;
         COND_SCAN_BUSY:  cond_true = (pend_in != '0) || rd_issue;
         COND_OUT_STALL:  cond_true = !can_load;
         default:         cond_true = 1'b0;
      endcase
      step_in = cond_true ? uc.jump_to : uc.fall_to;
   end

   // Hold sequencer, datapath and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= STEP_CLEAR;
         clr_addr_ff    <= '0;
         pend_ff        <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         codes_ff       <= '0;
         in_use_ff      <= '0;
      end else begin
         step_ff        <= step_in;
         clr_addr_ff    <= clr_addr_in;
         pend_ff        <= pend_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         codes_ff       <= codes_in;
         in_use_ff      <= in_use_in;
      end
      set_ff         <= set_in;
      acc_ff         <= acc_in;
      found_ff       <= found_in;
      col_ff         <= col_in;
      rsp_set_ff     <= rsp_set_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_unknown_ff <= rsp_unknown_in;
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_raddr];
   end

endmodule
